### rtl/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types, sizes and constants of the seen-address table.
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam int CNT7_W = 7;

  localparam logic [15:0] EN_UUID = 16'hfd6f;
  localparam logic [31:0] FORGET_RESET = 32'd1200000;
  localparam logic [CNT7_W-1:0] CNT7_MAX = 7'd127;

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_SWEEP = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [47:0] address;
    logic        has_service_uuid;
    logic [15:0] service_uuid;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              is_new;
    logic              table_full;
    logic [31:0]       new_total;
    logic [CNT7_W-1:0] removed_count;
    logic [CNT7_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] last_seen;
  } entry_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_stat_t;

  function automatic logic [CNT7_W-1:0] sat7(input logic [OCC_W-1:0] v);
    if (32'(v) > 32'(CNT7_MAX)) begin
      return CNT7_MAX;
    end else begin
      return CNT7_W'(v);
    end
  endfunction

endpackage

`default_nettype wire

### rtl/sat_ram.sv
// ----------------------------------------------------------------------------
// sat_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/sat_engine.sv
// ----------------------------------------------------------------------------
// sat_engine
// Walks the entry RAM at most once per item: lookup and insert for reports,
// aging for sweeps. Holds the valid bits, occupancy and the new-sender count.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start_i,
  input  wire sat_pkg::in_item_t  item_i,
  input  wire logic [31:0]        forget_i,
  input  wire logic               res_take_i,
  output      sat_pkg::eng_stat_t stat_o,
  output      sat_pkg::out_item_t res_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  sat_pkg::in_item_t            item_r, item_nxt;
  logic [sat_pkg::TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [sat_pkg::OCC_W-1:0]    occ_r, occ_nxt;
  logic [sat_pkg::OCC_W-1:0]    rem_r, rem_nxt;
  logic [31:0]                  cnt_r, cnt_nxt;
  logic [sat_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic                         iss_on_r, iss_on_nxt;
  logic                         cmp_vld_r, cmp_vld_nxt;
  logic [sat_pkg::IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                         free_ok_r, free_ok_nxt;
  logic [sat_pkg::IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic                         acc_r, acc_nxt;
  logic                         new_r, new_nxt;
  logic                         full_r, full_nxt;

  sat_pkg::entry_t              rd_data;
  sat_pkg::entry_t              wr_data;
  logic                         rd_en;
  logic                         wr_en;
  logic [sat_pkg::IDX_W-1:0]    wr_addr;

  logic                         in_scan;
  logic                         is_sweep;
  logic                         cur_valid;
  logic                         hit;
  logic                         aged;
  logic                         last;
  logic                         free_here;
  logic                         slot_ok;
  logic [sat_pkg::IDX_W-1:0]    slot_idx;
  logic                         finish;
  logic                         ins;
  logic                         drop;
  logic                         uuid_ok;
  logic [31:0]                  age;

  always_comb begin
    in_scan   = (state_r == ST_SCAN);
    is_sweep  = (item_r.req_type == sat_pkg::REQ_SWEEP);
    cur_valid = valid_r[cmp_idx_r];
    age       = item_r.now_ms - rd_data.last_seen;
    hit       = in_scan && cmp_vld_r && !is_sweep && cur_valid
                && (rd_data.addr == item_r.address);
    aged      = in_scan && cmp_vld_r && is_sweep && cur_valid && (age > forget_i);
    last      = in_scan && cmp_vld_r
                && (cmp_idx_r == sat_pkg::IDX_W'(sat_pkg::TABLE_DEPTH - 1));
    free_here = cmp_vld_r && !cur_valid;
    slot_ok   = free_ok_r || free_here;
    slot_idx  = free_ok_r ? free_idx_r : cmp_idx_r;
    finish    = hit || last;
    ins       = last && !is_sweep && !hit && slot_ok;
    drop      = last && !is_sweep && !hit && !slot_ok;
    uuid_ok   = item_i.has_service_uuid && (item_i.service_uuid == sat_pkg::EN_UUID);

    rd_en   = in_scan && iss_on_r && !finish;
    wr_en   = hit || ins;
    wr_addr = hit ? cmp_idx_r : slot_idx;
    wr_data = '{addr: item_r.address, last_seen: item_r.now_ms};
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    valid_nxt    = valid_r;
    occ_nxt      = occ_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    iss_on_nxt   = iss_on_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = idx_r;
    free_ok_nxt  = free_ok_r;
    free_idx_nxt = free_idx_r;
    acc_nxt      = acc_r;
    new_nxt      = new_r;
    full_nxt     = full_r;

    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          item_nxt    = item_i;
          rem_nxt     = '0;
          new_nxt     = 1'b0;
          full_nxt    = 1'b0;
          idx_nxt     = '0;
          free_ok_nxt = 1'b0;
          if (item_i.req_type == sat_pkg::REQ_SWEEP) begin
            acc_nxt    = 1'b0;
            iss_on_nxt = 1'b1;
            state_nxt  = ST_SCAN;
          end else if (uuid_ok) begin
            acc_nxt    = 1'b1;
            iss_on_nxt = 1'b1;
            state_nxt  = ST_SCAN;
          end else begin
            acc_nxt    = 1'b0;
            iss_on_nxt = 1'b0;
            state_nxt  = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r;
          if (idx_r == sat_pkg::IDX_W'(sat_pkg::TABLE_DEPTH - 1)) begin
            iss_on_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (free_here && !free_ok_r) begin
          free_ok_nxt  = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
        if (aged) begin
          valid_nxt[cmp_idx_r] = 1'b0;
          rem_nxt              = rem_r + 1'b1;
          occ_nxt              = occ_r - 1'b1;
        end
        if (ins) begin
          valid_nxt[slot_idx] = 1'b1;
          occ_nxt             = occ_r + 1'b1;
          new_nxt             = 1'b1;
          if (cnt_r != '1) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (drop) begin
          full_nxt = 1'b1;
        end
        if (finish) begin
          iss_on_nxt = 1'b0;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      occ_r     <= '0;
      rem_r     <= '0;
      cnt_r     <= '0;
      iss_on_r  <= 1'b0;
      cmp_vld_r <= 1'b0;
      free_ok_r <= 1'b0;
      acc_r     <= 1'b0;
      new_r     <= 1'b0;
      full_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      occ_r     <= occ_nxt;
      rem_r     <= rem_nxt;
      cnt_r     <= cnt_nxt;
      iss_on_r  <= iss_on_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      free_ok_r <= free_ok_nxt;
      acc_r     <= acc_nxt;
      new_r     <= new_nxt;
      full_r    <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  sat_ram #(
    .WIDTH($bits(sat_pkg::entry_t)),
    .DEPTH(sat_pkg::TABLE_DEPTH)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(idx_r),
    .rd_data(rd_data)
  );

  assign stat_o = '{idle: (state_r == ST_IDLE), res_valid: (state_r == ST_DONE)};
  assign res_o  = '{accepted:      acc_r,
                    is_new:        new_r,
                    table_full:    full_r,
                    new_total:     cnt_r,
                    removed_count: sat_pkg::sat7(rem_r),
                    occupancy:     sat_pkg::sat7(occ_r)};

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= 32'(sat_pkg::TABLE_DEPTH))
    else $error("occupancy exceeds table depth");

  a_wr_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> in_scan && !is_sweep)
    else $error("entry write outside a report scan");

  a_new_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !(new_r && full_r) && (acc_r || (!new_r && !full_r)))
    else $error("inconsistent result flags");

  a_ins_occ: assert property (@(posedge clk) disable iff (!rst_n)
    ins |=> occ_r == $past(occ_r) + 1'b1)
    else $error("insert did not raise occupancy");

  a_sweep_no_new: assert property (@(posedge clk) disable iff (!rst_n)
    (in_scan && is_sweep) |=> cnt_r == $past(cnt_r))
    else $error("sweep changed the new-sender count");

endmodule

`default_nettype wire

### rtl/seen_address_table_with_aging.sv
// ----------------------------------------------------------------------------
// seen_address_table_with_aging
// Table of seen radio addresses with last-seen times, lookup and aging.
//
//   Channel  Direction  Handshake         Payload
//   in_      input      in_valid/in_stall   sat_pkg::in_item_t
//   out_     output     out_valid/out_stall sat_pkg::out_item_t
//   cfg_     input      cfg_valid/cfg_ready forget interval, 32 bits
//
// A report or sweep walks the entry RAM one entry per cycle. Its result
// moves to the output register once that register is free, and the next
// input is taken after that; a report that finds its address stops early.
// A report that fails the UUID filter skips the walk and goes straight to
// its result.
// The single read port of the entry RAM limits the walk to this rate.
// Reset clears the valid bits at once; no clearing pass is needed.
// A new item is taken while a finished result still waits in the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module seen_address_table_with_aging (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire sat_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      sat_pkg::out_item_t out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [31:0]        cfg_data
);

  logic               out_valid_r, out_valid_nxt;
  sat_pkg::out_item_t out_data_r;
  logic [31:0]        forget_r;
  sat_pkg::eng_stat_t stat;
  sat_pkg::out_item_t res;
  logic               res_take;
  logic               start;

  assign in_stall  = !stat.idle;
  assign start     = in_valid && stat.idle;
  assign cfg_ready = 1'b1;
  assign res_take  = stat.res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      forget_r    <= sat_pkg::FORGET_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        forget_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  sat_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (start),
    .item_i    (in_data),
    .forget_i  (forget_r),
    .res_take_i(res_take),
    .stat_o    (stat),
    .res_o     (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
